// File: hw/rtl/cme_pkg.sv
// Package for the classification metrics engine: widths, mode codes, status codes,
// sequencer state codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
package cme_pkg;
    localparam int LABEL_W = 4;
    localparam int MODE_W = 2;
    localparam int CCNT_W = 5;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MICRO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MACRO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNSUP = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd2;

    // Controller phase codes, shared by the controller and the datapath.
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_ACC = 3'd0;
    localparam logic [PH_W-1:0] PH_SUM = 3'd1;
    localparam logic [PH_W-1:0] PH_DIV = 3'd2;
    localparam logic [PH_W-1:0] PH_MACC = 3'd3;
    localparam logic [PH_W-1:0] PH_AVG = 3'd4;
    localparam logic [PH_W-1:0] PH_OUT = 3'd5;

    // Divide jobs of the finalize pass
    localparam int JOB_W = 3;
    localparam logic [JOB_W-1:0] JOB_ACC = 3'd0;
    localparam logic [JOB_W-1:0] JOB_PREC = 3'd1;
    localparam logic [JOB_W-1:0] JOB_REC = 3'd2;
    localparam logic [JOB_W-1:0] JOB_F1 = 3'd3;

    // Controller -> datapath
    typedef struct packed {
        logic accum;      // count the input beat
        logic clr_sum;    // clear sum registers
        logic sum_step;   // add class entry into micro sums
        logic load_div;   // start the divider on the current job
        logic macc_step;  // add divider result into macro sums
        logic load_out;   // latch the output fields
        logic clear_all;  // clear counters
        logic [PH_W-1:0] phase;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic div_done;
    } t_sts;
endpackage

// File: hw/rtl/cme_stream_if.sv
// Valid/ready channel interface with a parametric payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface cme_stream_if #(
    parameter int W = 9
);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/classification_metrics_engine.sv
// Top level of the classification metrics engine: controller FSM, config
// registers, datapath. Depends on cme_pkg, cme_stream_if, cme_datapath.
//
//   channel   dir   payload                                   handshake
//   s_in      in    true_label, predicted_label, last_sample  valid/ready
//   m_out     out   accuracy, precision, recall, f_score, st  valid/ready
//   cfg       in    i_cfg_we, i_cfg_idx, i_cfg_data           write strobe
//
// Beats that are not last are taken back to back. A last beat starts a finalize
// pass paced by the shared bit-serial divider, QW = 38 by default: a sum sweep
// of all M = MAX_CLASSES classes, then four divides (binary/micro), or (macro)
// an accuracy divide, three per class and three averaging divides. Input stalls
// during the pass; it holds at its end while an earlier result still waits.
// Synchronous active-low reset clears counters and sets average_mode 0, class_count 2.
`timescale 1ns / 1ps
module classification_metrics_engine #(
    parameter int MAX_CLASSES = 16,
    parameter int MAX_SAMPLES = 65536,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cme_stream_if.sink   s_in,
    cme_stream_if.source m_out,
    input  logic i_cfg_we,
    input  logic [cme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cme_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CIW = $clog2(MAX_CLASSES);

    logic [cme_pkg::MODE_W-1:0] r_mode;
    logic [cme_pkg::CCNT_W-1:0] r_ccnt;
    logic [cme_pkg::PH_W-1:0] r_ph, n_ph;
    logic [CIW-1:0] r_cls, n_cls;
    logic [cme_pkg::JOB_W-1:0] r_job, n_job;
    logic r_busy, n_busy, r_ovalid, n_ovalid, r_wait, n_wait;
    cme_pkg::t_cmd w_cmd;
    cme_pkg::t_sts w_sts;
    logic w_acc_beat;
    logic [FRACTION_BITS:0] w_acc, w_prec, w_rec, w_f1;
    logic [cme_pkg::STAT_W-1:0] w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cme_pkg::MODE_BINARY;
            r_ccnt <= 5'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cme_pkg::REG_AVERAGE_MODE: r_mode <= i_cfg_data[cme_pkg::MODE_W-1:0];
                default: r_ccnt <= i_cfg_data;
            endcase
        end
    end

    assign s_in.ready = !r_busy;
    assign w_acc_beat = s_in.valid && s_in.ready;
    wire w_last_cls = (r_cls == CIW'(MAX_CLASSES - 1));

    // Sequencer: SUM sweep -> DIV jobs; macro: ACC only, MACC per class+job, AVG
    always_comb begin
        n_ph = r_ph;
        n_cls = r_cls;
        n_job = r_job;
        n_busy = r_busy;
        n_ovalid = r_ovalid;
        n_wait = r_wait;
        w_cmd = '0;
        w_cmd.phase = r_ph;
        w_cmd.accum = w_acc_beat;
        if (r_ovalid && m_out.ready) n_ovalid = 1'b0;
        if (w_acc_beat && s_in.data[0]) begin
            n_busy = 1'b1;
            n_ph = cme_pkg::PH_SUM;
            n_cls = '0;
            n_job = cme_pkg::JOB_ACC;
            n_wait = 1'b0;
            w_cmd.clr_sum = 1'b1;
        end else if (r_busy) begin
            unique case (r_ph) inside
                cme_pkg::PH_SUM: begin
                    w_cmd.sum_step = 1'b1;
                    n_cls = r_cls + 1'b1;
                    if (w_last_cls) begin
                        n_cls = '0;
                        n_ph = cme_pkg::PH_DIV;
                    end
                end
                cme_pkg::PH_DIV, cme_pkg::PH_AVG: begin
                    if (!r_wait) begin
                        w_cmd.load_div = 1'b1;
                        n_wait = 1'b1;
                    end else if (w_sts.div_done) begin
                        n_wait = 1'b0;
                        n_job = r_job + 1'b1;
                        if (r_job == cme_pkg::JOB_F1) begin
                            n_job = cme_pkg::JOB_PREC;
                            if (r_ph == cme_pkg::PH_DIV && r_mode == cme_pkg::MODE_MACRO) begin
                                n_ph = cme_pkg::PH_MACC;
                            end else begin
                                n_ph = cme_pkg::PH_OUT;
                            end
                        end
                        if (r_ph == cme_pkg::PH_DIV && r_mode == cme_pkg::MODE_MACRO
                            && r_job == cme_pkg::JOB_ACC) begin
                            n_job = cme_pkg::JOB_PREC;
                            n_ph = cme_pkg::PH_MACC;
                        end
                    end
                end
                cme_pkg::PH_MACC: begin
                    if (!r_wait) begin
                        w_cmd.load_div = 1'b1;
                        n_wait = 1'b1;
                    end else if (w_sts.div_done) begin
                        w_cmd.macc_step = 1'b1;
                        n_wait = 1'b0;
                        n_job = r_job + 1'b1;
                        if (r_job == cme_pkg::JOB_F1) begin
                            n_job = cme_pkg::JOB_PREC;
                            n_cls = r_cls + 1'b1;
                            if (w_last_cls) begin
                                n_cls = '0;
                                n_ph = cme_pkg::PH_AVG;
                            end
                        end
                    end
                end
                default: begin
                    // wait here until the output register is free
                    if (!r_ovalid || m_out.ready) begin
                        w_cmd.load_out = 1'b1;
                        w_cmd.clear_all = 1'b1;
                        n_busy = 1'b0;
                        n_ovalid = 1'b1;
                        n_ph = cme_pkg::PH_ACC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= cme_pkg::PH_ACC;
            r_cls <= '0;
            r_job <= cme_pkg::JOB_ACC;
            r_busy <= 1'b0;
            r_ovalid <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_cls <= n_cls;
            r_job <= n_job;
            r_busy <= n_busy;
            r_ovalid <= n_ovalid;
            r_wait <= n_wait;
        end
    end

    cme_datapath #(
        .MAX_CLASSES   (MAX_CLASSES),
        .MAX_SAMPLES   (MAX_SAMPLES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_true   (s_in.data[8:5]),
        .i_pred   (s_in.data[4:1]),
        .i_mode   (r_mode),
        .i_ccnt   (r_ccnt),
        .i_cls    (r_cls),
        .i_job    (r_job),
        .o_acc    (w_acc),
        .o_prec   (w_prec),
        .o_rec    (w_rec),
        .o_f1     (w_f1),
        .o_status (w_status)
    );

    assign m_out.valid = r_ovalid;
    assign m_out.data = {w_acc, w_prec, w_rec, w_f1, w_status};

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_out.ready |=> r_ovalid && $stable(m_out.data))
        else $error("result beat changed while waiting");
    a_out_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> r_ovalid) else $error("finish without result");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !w_acc_beat) else $error("beat accepted while busy");
`endif
endmodule

// File: hw/rtl/cme_divider.sv
// Restoring divider, one quotient bit per cycle: q = floor(n * 2^FB / d), 0 when d == 0.
// Depends on nothing.
`timescale 1ns / 1ps
module cme_divider #(
    parameter int NW = 20,
    parameter int FB = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic          o_done,
    output logic [NW+FB-1:0] o_quot
);
    localparam int QW = NW + FB;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_dvd, n_dvd;
    logic [NW:0]   r_rem, n_rem;
    logic [NW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done, r_zero;
    logic [NW:0]   w_trial;

    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[NW-1:0], r_dvd[QW-1]};
        if (i_start) begin
            n_dvd = {i_num, {FB{1'b0}}};
            n_rem = '0;
            n_cnt = CW'(QW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_dvd = {r_dvd[QW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_dvd = {r_dvd[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
            r_zero <= (i_den == '0);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_dvd;
endmodule

// File: hw/rtl/cme_datapath.sv
// Datapath: per-class counter memories, totals, micro/macro sums, divider and
// output register. Depends on cme_pkg and cme_divider.
`timescale 1ns / 1ps
module cme_datapath #(
    parameter int MAX_CLASSES = 16,
    parameter int MAX_SAMPLES = 65536,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  cme_pkg::t_cmd i_cmd,
    output cme_pkg::t_sts o_sts,
    input  logic [cme_pkg::LABEL_W-1:0] i_true,
    input  logic [cme_pkg::LABEL_W-1:0] i_pred,
    input  logic [cme_pkg::MODE_W-1:0] i_mode,
    input  logic [cme_pkg::CCNT_W-1:0] i_ccnt,
    input  logic [$clog2(MAX_CLASSES)-1:0] i_cls,   // class index for sweeps
    input  logic [cme_pkg::JOB_W-1:0] i_job,
    output logic [FRACTION_BITS:0] o_acc,
    output logic [FRACTION_BITS:0] o_prec,
    output logic [FRACTION_BITS:0] o_rec,
    output logic [FRACTION_BITS:0] o_f1,
    output logic [cme_pkg::STAT_W-1:0] o_status
);
    localparam int CIW = $clog2(MAX_CLASSES);
    localparam int CNW = $clog2(MAX_SAMPLES + 1);
    // macro sums: up to MAX_CLASSES fractions of at most 2^FB each
    localparam int SW = FRACTION_BITS + 1 + CIW + 1;
    // 2*tp+fp+fn is at most twice the item count; macro sums go through the divider too
    localparam int NW = (CNW + 2 > SW) ? CNW + 2 : SW;
    localparam int QW = NW + FRACTION_BITS;
    localparam int OW = FRACTION_BITS + 1;

    logic [CNW-1:0] r_tp [MAX_CLASSES];
    logic [CNW-1:0] r_fp [MAX_CLASSES];
    logic [CNW-1:0] r_fn [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] r_tpv, r_fpv, r_fnv;
    logic [CNW-1:0] r_total, r_correct;
    logic [cme_pkg::LABEL_W-1:0] r_largest;
    logic r_ovf;
    logic [NW-1:0] r_stp, r_sfp, r_sfn;
    logic [SW-1:0] r_sp, r_sr, r_sf;
    logic [CNW-1:0] w_tp, w_fp, w_fn;
    logic [NW-1:0] w_num, w_den;
    logic [QW-1:0] w_quot;
    logic w_start, w_done;
    logic [4:0] w_nc;
    logic w_unsup, w_cls_ok;
    logic [SW-1:0] w_macc_src;
    logic [cme_pkg::STAT_W-1:0] w_stat;
    logic [OW-1:0] r_acc, r_prec, r_rec, r_f1;
    logic [OW-1:0] r_oacc, r_oprec, r_orec, r_of1;
    logic [cme_pkg::STAT_W-1:0] r_status;

    wire w_true_in = (32'(i_true) < MAX_CLASSES);
    wire w_pred_in = (32'(i_pred) < MAX_CLASSES);
    wire [CIW-1:0] w_ti = CIW'(i_true);
    wire [CIW-1:0] w_pi = CIW'(i_pred);

    // Counter memories: a beat updates tp, or fp and fn; unset entries read zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_tpv <= '0;
            r_fpv <= '0;
            r_fnv <= '0;
            r_total <= '0;
            r_correct <= '0;
            r_largest <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.accum) begin
            if (32'(r_total) >= MAX_SAMPLES) begin
                r_ovf <= 1'b1;
            end else begin
                r_total <= r_total + 1'b1;
                if (i_true > r_largest) r_largest <= i_true;
                if (i_true == i_pred) begin
                    r_correct <= r_correct + 1'b1;
                    if (w_true_in) begin
                        r_tp[w_ti] <= (r_tpv[w_ti] ? r_tp[w_ti] : '0) + 1'b1;
                        r_tpv[w_ti] <= 1'b1;
                    end
                end else begin
                    if (w_pred_in) begin
                        r_fp[w_pi] <= (r_fpv[w_pi] ? r_fp[w_pi] : '0) + 1'b1;
                        r_fpv[w_pi] <= 1'b1;
                    end
                    if (w_true_in) begin
                        r_fn[w_ti] <= (r_fnv[w_ti] ? r_fn[w_ti] : '0) + 1'b1;
                        r_fnv[w_ti] <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        w_tp = r_tpv[i_cls] ? r_tp[i_cls] : '0;
        w_fp = r_fpv[i_cls] ? r_fp[i_cls] : '0;
        w_fn = r_fnv[i_cls] ? r_fn[i_cls] : '0;
    end

    assign w_nc = (i_ccnt == '0) ? 5'(r_largest) + 5'd1 : i_ccnt;
    assign w_cls_ok = (32'(i_cls) < 32'(w_nc));
    assign w_unsup = (i_mode == cme_pkg::MODE_BAD) ||
                     (i_mode == cme_pkg::MODE_BINARY && i_ccnt != 5'd2);

    // Micro sums (binary mode sums only class 1) and macro sums of divider results
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_sum) begin
            r_stp <= '0;
            r_sfp <= '0;
            r_sfn <= '0;
            r_sp <= '0;
            r_sr <= '0;
            r_sf <= '0;
        end else begin
            if (i_cmd.sum_step && w_cls_ok &&
                (i_mode != cme_pkg::MODE_BINARY || 32'(i_cls) == 1)) begin
                r_stp <= r_stp + NW'(w_tp);
                r_sfp <= r_sfp + NW'(w_fp);
                r_sfn <= r_sfn + NW'(w_fn);
            end
            if (i_cmd.macc_step) begin
                unique case (i_job)
                    cme_pkg::JOB_PREC: r_sp <= r_sp + w_macc_src;
                    cme_pkg::JOB_REC: r_sr <= r_sr + w_macc_src;
                    default: r_sf <= r_sf + w_macc_src;
                endcase
            end
        end
    end

    // Divider operand selection
    always_comb begin
        logic [NW-1:0] tp, fp, fn;
        if (i_cmd.phase == cme_pkg::PH_DIV) begin
            tp = r_stp;
            fp = r_sfp;
            fn = r_sfn;
        end else begin
            tp = NW'(w_tp);
            fp = NW'(w_fp);
            fn = NW'(w_fn);
        end
        w_num = '0;
        w_den = '0;
        if (i_cmd.phase == cme_pkg::PH_AVG) begin
            // floor(S * 2^FB / nc) >> FB is floor(S / nc)
            unique case (i_job)
                cme_pkg::JOB_PREC: w_num = NW'(r_sp);
                cme_pkg::JOB_REC: w_num = NW'(r_sr);
                default: w_num = NW'(r_sf);
            endcase
            w_den = NW'(w_nc);
        end else begin
            unique case (i_job)
                cme_pkg::JOB_ACC: begin
                    w_num = NW'(r_correct);
                    w_den = NW'(r_total);
                end
                cme_pkg::JOB_PREC: begin
                    w_num = tp;
                    w_den = tp + fp;
                end
                cme_pkg::JOB_REC: begin
                    w_num = tp;
                    w_den = tp + fn;
                end
                default: begin
                    w_num = tp << 1;
                    w_den = (tp << 1) + fp + fn;
                end
            endcase
        end
    end

    assign w_start = i_cmd.load_div;
    assign w_macc_src = (w_cls_ok) ? SW'(w_quot) : '0;

    cme_divider #(.NW(NW), .FB(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign w_stat = w_unsup ? cme_pkg::STAT_UNSUP :
                    r_ovf ? cme_pkg::STAT_OVF : cme_pkg::STAT_OK;

    // Working results, one per divide job
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (i_cmd.phase == cme_pkg::PH_AVG) begin
                unique case (i_job)
                    cme_pkg::JOB_PREC: r_prec <= OW'(w_quot >> FRACTION_BITS);
                    cme_pkg::JOB_REC: r_rec <= OW'(w_quot >> FRACTION_BITS);
                    default: r_f1 <= OW'(w_quot >> FRACTION_BITS);
                endcase
            end else if (i_cmd.phase != cme_pkg::PH_MACC) begin
                unique case (i_job)
                    cme_pkg::JOB_ACC: r_acc <= OW'(w_quot);
                    cme_pkg::JOB_PREC: r_prec <= OW'(w_quot);
                    cme_pkg::JOB_REC: r_rec <= OW'(w_quot);
                    default: r_f1 <= OW'(w_quot);
                endcase
            end
        end
    end

    // Output register: holds the result beat while the next set streams in
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= w_stat;
            r_oacc <= (w_stat == cme_pkg::STAT_OK) ? r_acc : '0;
            r_oprec <= (w_stat == cme_pkg::STAT_OK) ? r_prec : '0;
            r_orec <= (w_stat == cme_pkg::STAT_OK) ? r_rec : '0;
            r_of1 <= (w_stat == cme_pkg::STAT_OK) ? r_f1 : '0;
        end
    end

    assign o_sts.div_done = w_done;
    assign o_acc = r_oacc;
    assign o_prec = r_oprec;
    assign o_rec = r_orec;
    assign o_f1 = r_of1;
    assign o_status = r_status;
endmodule

// File: sim/classification_metrics_engine_tb.sv
// Self-checking testbench for classification_metrics_engine: streams label pairs,
// predicts accuracy/precision/recall/F1 per set and compares each output beat.
// Depends on cme_pkg, cme_stream_if and the engine RTL.
`timescale 1ns / 1ps
module classification_metrics_engine_tb;
    localparam int NCLS = 16;
    localparam int SAMPLE_CAP = 65536;
    localparam int FB = 16;
    localparam int MW = FB + 1;
    localparam int LBL_W = cme_pkg::LABEL_W;
    localparam int MODE_BITS = cme_pkg::MODE_W;
    localparam int CCNT_BITS = cme_pkg::CCNT_W;
    localparam int IDX_BITS = cme_pkg::CFG_IDX_W;
    localparam int DATA_BITS = cme_pkg::CFG_DATA_W;
    localparam int ST_BITS = cme_pkg::STAT_W;
    localparam int OUT_W = 4 * MW + ST_BITS;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [MW-1:0] accuracy;
        logic [MW-1:0] precision;
        logic [MW-1:0] recall;
        logic [MW-1:0] f_score;
        logic [ST_BITS-1:0] status;
    } t_metrics;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_BITS-1:0] i_cfg_idx;
    logic [DATA_BITS-1:0] i_cfg_data;

    cme_stream_if #(.W(2 * LBL_W + 1)) s_in ();
    cme_stream_if #(.W(OUT_W)) m_out ();

    classification_metrics_engine i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_in(s_in),
        .m_out(m_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    int unsigned tp_cnt[NCLS];
    int unsigned fp_cnt[NCLS];
    int unsigned fn_cnt[NCLS];
    int unsigned n_samples;
    int unsigned n_correct;
    int unsigned top_label;
    bit saw_overflow;
    logic [MODE_BITS-1:0] avg_mode;
    logic [CCNT_BITS-1:0] n_classes;

    t_metrics pending_metrics[$];
    int errors;
    int n_beats;
    int n_sets;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned ratio(longint unsigned num, longint unsigned den);
        if (den == 0) return 0;
        return (num << FB) / den;
    endfunction

    function automatic void clear_counts();
        for (int c = 0; c < NCLS; c++) begin
            tp_cnt[c] = 0;
            fp_cnt[c] = 0;
            fn_cnt[c] = 0;
        end
        n_samples = 0;
        n_correct = 0;
        top_label = 0;
        saw_overflow = 0;
    endfunction

    // count one accepted beat; on the last beat of a set queue the expected metrics
    function automatic void count_beat(int unsigned t, int unsigned p, bit last);
        t_metrics m;
        int unsigned nc, lim;
        longint unsigned tp, fp, fn, sp, sr, sf;
        if (n_samples >= SAMPLE_CAP) begin
            saw_overflow = 1;
        end else begin
            n_samples++;
            if (t > top_label) top_label = t;
            if (t == p) begin
                n_correct++;
                tp_cnt[t]++;
            end else begin
                fp_cnt[p]++;
                fn_cnt[t]++;
            end
        end
        if (!last) return;
        m = '0;
        nc = (n_classes == 0) ? top_label + 1 : n_classes;
        lim = (nc < NCLS) ? nc : NCLS;
        if (avg_mode == cme_pkg::MODE_BAD ||
            (avg_mode == cme_pkg::MODE_BINARY && n_classes != 2)) begin
            m.status = cme_pkg::STAT_UNSUP;
        end else if (saw_overflow) begin
            m.status = cme_pkg::STAT_OVF;
        end else begin
            m.status = cme_pkg::STAT_OK;
            m.accuracy = MW'(ratio(n_correct, n_samples));
            if (avg_mode != cme_pkg::MODE_MACRO) begin
                tp = 0; fp = 0; fn = 0;
                if (avg_mode == cme_pkg::MODE_BINARY) begin
                    tp = tp_cnt[1]; fp = fp_cnt[1]; fn = fn_cnt[1];
                end else begin
                    for (int c = 0; c < lim; c++) begin
                        tp += tp_cnt[c]; fp += fp_cnt[c]; fn += fn_cnt[c];
                    end
                end
                m.precision = MW'(ratio(tp, tp + fp));
                m.recall = MW'(ratio(tp, tp + fn));
                m.f_score = MW'(ratio(2 * tp, 2 * tp + fp + fn));
            end else begin
                sp = 0; sr = 0; sf = 0;
                for (int c = 0; c < lim; c++) begin
                    tp = tp_cnt[c]; fp = fp_cnt[c]; fn = fn_cnt[c];
                    sp += ratio(tp, tp + fp);
                    sr += ratio(tp, tp + fn);
                    sf += ratio(2 * tp, 2 * tp + fp + fn);
                end
                m.precision = MW'(sp / nc);
                m.recall = MW'(sr / nc);
                m.f_score = MW'(sf / nc);
            end
        end
        pending_metrics = {pending_metrics, m};
        clear_counts();
    endfunction

    // sink side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_out.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_out.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_metrics got, want;
        if (m_out.valid && m_out.ready && i_rst_n) begin
            got = m_out.data;
            if (pending_metrics.size() == 0) begin
                $error("unexpected result beat %h", got);
                errors++;
            end else begin
                want = pending_metrics.pop_front();
                n_sets++;
                if (got.accuracy !== want.accuracy) begin
                    $error("accuracy: expected %0d, got %0d", want.accuracy, got.accuracy);
                    errors++;
                end
                if (got.precision !== want.precision) begin
                    $error("precision: expected %0d, got %0d", want.precision, got.precision);
                    errors++;
                end
                if (got.recall !== want.recall) begin
                    $error("recall: expected %0d, got %0d", want.recall, got.recall);
                    errors++;
                end
                if (got.f_score !== want.f_score) begin
                    $error("f_score: expected %0d, got %0d", want.f_score, got.f_score);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(int unsigned t, int unsigned p, bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data <= {LBL_W'(t), LBL_W'(p), last};
        do @(posedge i_clk); while (!s_in.ready);
        count_beat(t, p, last);
        n_beats++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_in.valid <= 1'b0;
        while (pending_metrics.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_BITS-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= DATA_BITS'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cme_pkg::REG_AVERAGE_MODE) avg_mode = MODE_BITS'(value);
        else n_classes = CCNT_BITS'(value);
    endtask

    task automatic set_mode(logic [MODE_BITS-1:0] mode, int unsigned classes);
        drain();
        write_reg(cme_pkg::REG_AVERAGE_MODE, 32'(mode));
        write_reg(cme_pkg::REG_CLASS_COUNT, classes);
    endtask

    // a set of len beats, labels drawn from 0 to lbl_top, roughly hit_pct correct
    task automatic send_set(int len, int unsigned lbl_top, int hit_pct);
        int unsigned t, p;
        for (int k = 0; k < len; k++) begin
            t = $urandom_range(lbl_top);
            p = ($urandom_range(99) < hit_pct) ? t : $urandom_range(lbl_top);
            send_beat(t, p, k == len - 1);
        end
    endtask

    task automatic test_directed();
        // reset defaults: binary with two classes
        send_beat(1, 1, 0);
        send_beat(0, 1, 0);
        send_beat(1, 0, 1);
        send_beat(0, 0, 1);           // no class-1 entries: empty denominators
        set_mode(cme_pkg::MODE_MICRO, 16);
        send_beat(15, 15, 0);
        send_beat(0, 15, 0);
        send_beat(15, 0, 1);
        send_beat(3, 7, 1);           // single wrong beat
        set_mode(cme_pkg::MODE_MACRO, 0);      // class count from largest label
        send_beat(2, 2, 0);
        send_beat(5, 1, 0);
        send_beat(15, 15, 1);
        set_mode(cme_pkg::MODE_MACRO, 16);
        send_beat(9, 9, 1);
        set_mode(cme_pkg::MODE_MACRO, 20);     // above the class capacity
        send_beat(4, 4, 0);
        send_beat(4, 6, 1);
        set_mode(cme_pkg::MODE_BINARY, 5);     // unsupported
        send_beat(1, 1, 1);
        set_mode(cme_pkg::MODE_BAD, 2);        // unsupported
        send_beat(1, 0, 1);
        set_mode(cme_pkg::MODE_MICRO, 0);
        send_beat(0, 0, 1);
        set_mode(cme_pkg::MODE_MICRO, 1);
        send_beat(0, 0, 0);
        send_beat(7, 3, 1);
    endtask

    task automatic test_random(int n_items);
        int sent;
        int len;
        logic [MODE_BITS-1:0] mode;
        int unsigned classes, top;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(5))
                0: begin mode = cme_pkg::MODE_BINARY; classes = 2; end
                1: begin mode = cme_pkg::MODE_MICRO; classes = $urandom_range(16); end
                2: begin mode = cme_pkg::MODE_MACRO; classes = $urandom_range(16); end
                3: begin mode = cme_pkg::MODE_MACRO; classes = $urandom_range(16); end
                4: begin mode = cme_pkg::MODE_MICRO; classes = 16; end
                default: begin
                    mode = MODE_BITS'($urandom_range(3));
                    classes = $urandom_range(31);
                end
            endcase
            set_mode(mode, classes);
            for (int s = 0; s < 3 && sent < n_items; s++) begin
                top = (classes >= 2 && classes <= 16 && $urandom_range(3) != 0) ?
                      classes - 1 : 15;
                len = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 25);
                send_set(len, top, $urandom_range(20, 90));
                sent += len;
            end
        end
    endtask

    task automatic test_backpressure();
        set_mode(cme_pkg::MODE_MACRO, 8);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_cycles = 3000;
        for (int s = 0; s < 4; s++) send_set(6, 7, 50);
    endtask

    initial begin
        errors = 0;
        n_beats = 0;
        n_sets = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_in.valid = 1'b0;
        s_in.data = '0;
        m_out.ready = 1'b0;
        avg_mode = cme_pkg::MODE_BINARY;
        n_classes = 2;
        clear_counts();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(300);
        src_idle_pct = 80; snk_stall_pct = 0;
        test_random(250);
        src_idle_pct = 0; snk_stall_pct = 80;
        test_random(250);
        src_idle_pct = 38; snk_stall_pct = 38;
        test_random(300);
        test_backpressure();
        drain();

        $display("covered %0d input beats and %0d result sets", n_beats, n_sets);
        $display("binary/micro/macro modes, unsupported modes, derived class count, long stall");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/cme_pkg.sv
hw/rtl/cme_stream_if.sv
hw/rtl/cme_divider.sv
hw/rtl/cme_datapath.sv
hw/rtl/classification_metrics_engine.sv
sim/classification_metrics_engine_tb.sv
